### sv/kalc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kalc_pkg
// Shared types and constants of the keypad alarm lock controller.
// ----------------------------------------------------------------------------
package kalc_pkg;

	localparam int PASSWORD_LENGTH = 8;
	localparam int IDX_W           = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
	localparam int LEN_W           = $clog2(PASSWORD_LENGTH + 1);
	localparam int ENT_LEN_W       = 4;
	localparam int CNT_W           = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	localparam logic [7:0] SETPOINT_RESET  = 8'd28;
	localparam logic [7:0] TOLERANCE_RESET = 8'd3;

	// register indexes on the configuration port
	localparam logic REG_SETPOINT  = 1'b0;
	localparam logic REG_TOLERANCE = 1'b1;

	// key symbols
	localparam logic [7:0] KEY_ENTER   = 8'h41; // 'A'
	localparam logic [7:0] KEY_INSERT  = 8'h42; // 'B'
	localparam logic [7:0] KEY_CHANGE  = 8'h43; // 'C'
	localparam logic [7:0] KEY_DELETE  = 8'h44; // 'D'
	localparam logic [7:0] KEY_CANCEL  = 8'h2A; // '*'
	localparam logic [7:0] KEY_ARM     = 8'h23; // '#'
	localparam logic [7:0] KEY_DIGIT_0 = 8'h30;
	localparam logic [7:0] KEY_DIGIT_9 = 8'h39;

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_CHANGE = 3'd1,
		MODE_ENTER  = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_CANCEL = 3'd4,
		MODE_ARM    = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		CHG_NONE    = 2'd0,
		CHG_DONE    = 2'd1,
		CHG_REFUSED = 2'd2
	} chg_status_t;

	// commands to the entry / password store
	typedef struct packed {
		logic       digit_we;
		logic [3:0] digit;
		logic       clear;
		logic       commit;
	} kp_cmd_t;

	// status back from the entry / password store
	typedef struct packed {
		logic             full;
		logic             match;
		logic [LEN_W-1:0] length;
	} kp_stat_t;

endpackage
`default_nettype wire

### sv/kalc_keypad.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kalc_keypad
// Entry digit buffer, digit counter and stored password with full compare.
// ----------------------------------------------------------------------------
module kalc_keypad
	import kalc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire kp_cmd_t  cmd,
	output kp_stat_t      stat
);

	logic [3:0]       entry_q [PASSWORD_LENGTH];
	logic [3:0]       password_q [PASSWORD_LENGTH];
	logic [CNT_W-1:0] digit_count_q;
	logic [LEN_W-1:0] entry_length_q;
	logic             room;
	logic             equal;

	assign room = digit_count_q < CNT_W'(PASSWORD_LENGTH);

	// entry buffer holds no reset, it is only read once fully written
	always_ff @(posedge clk) begin
		if (cmd.digit_we && room) begin
			entry_q[digit_count_q[IDX_W-1:0]] <= cmd.digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q  <= '0;
			entry_length_q <= '0;
		end else if (cmd.clear) begin
			digit_count_q  <= '0;
			entry_length_q <= '0;
		end else if (cmd.digit_we) begin
			if (room) begin
				entry_length_q <= LEN_W'(digit_count_q + 1'b1);
			end
			if (digit_count_q != CNT_MAX) begin
				digit_count_q <= digit_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PASSWORD_LENGTH; i++) begin
				password_q[i] <= 4'(i % 10);
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < PASSWORD_LENGTH; i++) begin
				password_q[i] <= entry_q[i];
			end
		end
	end

	always_comb begin
		equal = 1'b1;
		for (int i = 0; i < PASSWORD_LENGTH; i++) begin
			if (entry_q[i] != password_q[i]) begin
				equal = 1'b0;
			end
		end
	end

	assign stat.full   = entry_length_q == LEN_W'(PASSWORD_LENGTH);
	assign stat.match  = stat.full && equal;
	assign stat.length = entry_length_q;

endmodule
`default_nettype wire

### sv/keypad_alarm_lock_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_alarm_lock_controller
// Per-tick door distance check, alarm/buzzer decision and keypad password
// entry, change and check.
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   one polling tick: key code, measured distance
// m_axis    out  one status beat per tick
// cfg       in   setpoint / tolerance write, no handshake
//
// one tick per cycle sustained while m_axis accepts; a tick passes to m_axis
// through its registers (input register, then result register)
// all tick logic (window check, key decode, 8-digit compare) sits between
// those two registers
// reset: armed, trip clear, insert mode, empty entry, password 0..7
// an unaccepted result holds the input register, which stalls s_axis
// ----------------------------------------------------------------------------
module keypad_alarm_lock_controller
	import kalc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // key_code[7:0], distance_cm[15:8]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // buzzer_on[0], armed[1], distance_safe[2],
	                                        // mode_code[5:3], entered_length[9:6],
	                                        // change_status[11:10], zero[15:12]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	logic [7:0] setpoint_q;
	logic [7:0] tolerance_q;

	logic       valid_s1;
	logic [7:0] key_s1;
	logic [7:0] dist_s1;

	logic       armed_q;
	logic       trip_q;
	mode_t      mode_q;

	logic       out_free;
	logic       adv;

	logic [7:0]  abs_diff;
	logic        safe;
	logic        trip_n;
	logic        buzzer;
	logic        is_opt;
	logic        is_digit;
	mode_t       opt_mode;
	mode_t       mode_key;
	mode_t       mode_n;
	logic        armed_n;
	logic        trip_nx;
	chg_status_t status;
	kp_cmd_t     cmd_raw;
	kp_cmd_t     cmd;
	kp_stat_t    kp_stat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= SETPOINT_RESET;
			tolerance_q <= TOLERANCE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:  setpoint_q  <= cfg_wdata;
				REG_TOLERANCE: tolerance_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// handshake
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			key_s1  <= s_axis_tdata[7:0];
			dist_s1 <= s_axis_tdata[15:8];
		end
	end

	// distance window and buzzer, decided before the key
	assign abs_diff = (setpoint_q >= dist_s1) ? (setpoint_q - dist_s1) : (dist_s1 - setpoint_q);
	assign safe     = abs_diff <= tolerance_q;
	assign trip_n   = trip_q || !safe;
	assign buzzer   = armed_q && trip_n;

	// key decode
	always_comb begin
		is_opt   = 1'b1;
		opt_mode = MODE_INSERT;
		unique case (key_s1)
			KEY_INSERT: opt_mode = MODE_INSERT;
			KEY_CHANGE: opt_mode = MODE_CHANGE;
			KEY_ENTER:  opt_mode = MODE_ENTER;
			KEY_DELETE: opt_mode = MODE_DELETE;
			KEY_CANCEL: opt_mode = MODE_CANCEL;
			KEY_ARM:    opt_mode = MODE_ARM;
			default:    is_opt   = 1'b0;
		endcase
	end

	assign is_digit = (key_s1 >= KEY_DIGIT_0) && (key_s1 <= KEY_DIGIT_9);
	assign mode_key = is_opt ? opt_mode : mode_q;

	// tick action
	always_comb begin
		armed_n        = armed_q;
		trip_nx        = trip_n;
		mode_n         = mode_key;
		status         = CHG_NONE;
		cmd_raw        = '0;
		cmd_raw.digit  = 4'(key_s1 - KEY_DIGIT_0);
		if (mode_q == MODE_INSERT && mode_key == MODE_ENTER) begin
			if (kp_stat.match) begin
				armed_n = 1'b0;
				trip_nx = 1'b0;
			end else begin
				armed_n = 1'b1;
			end
			cmd_raw.clear = 1'b1;
			mode_n        = MODE_INSERT;
		end else if (mode_q == MODE_CHANGE && mode_key == MODE_ENTER) begin
			if (kp_stat.full && !armed_q) begin
				cmd_raw.commit = 1'b1;
				status         = CHG_DONE;
			end else begin
				status = CHG_REFUSED;
			end
			cmd_raw.clear = 1'b1;
			mode_n        = MODE_INSERT;
		end else begin
			unique case (mode_key)
				MODE_INSERT, MODE_CHANGE: cmd_raw.digit_we = is_digit;
				MODE_DELETE: begin
					cmd_raw.clear = 1'b1;
					mode_n        = mode_q;
				end
				MODE_CANCEL: begin
					cmd_raw.clear = 1'b1;
					mode_n        = MODE_INSERT;
				end
				MODE_ARM: begin
					armed_n       = 1'b1;
					trip_nx       = 1'b0;
					cmd_raw.clear = 1'b1;
					mode_n        = MODE_INSERT;
				end
				default: ;
			endcase
		end
	end

	assign cmd = adv ? cmd_raw : '0;

	kalc_keypad u_keypad (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (kp_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b1;
			trip_q  <= 1'b0;
			mode_q  <= MODE_INSERT;
		end else if (adv) begin
			armed_q <= armed_n;
			trip_q  <= trip_nx;
			mode_q  <= mode_n;
		end
	end

	// result register; length is the store's length as it will stand after this tick's update
	logic [ENT_LEN_W-1:0] len_after;
	always_comb begin
		if (cmd_raw.clear) begin
			len_after = '0;
		end else if (cmd_raw.digit_we && !kp_stat.full) begin
			len_after = ENT_LEN_W'(kp_stat.length + 1'b1);
		end else begin
			len_after = ENT_LEN_W'(kp_stat.length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {4'b0000, status, len_after, mode_n, safe, armed_n, buzzer};
		end
	end

`ifndef SYNTHESIS
	// a stalled tick keeps its input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(key_s1) && $stable(dist_s1))
		else $error("input register changed while stalled");

	// a stored password implies disarmed, insert mode and empty entry
	a_change_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && status == CHG_DONE |=> !armed_q && mode_q == MODE_INSERT
		&& kp_stat.length == '0)
		else $error("password change left inconsistent state");

	// entry length never passes the password length
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kp_stat.length <= LEN_W'(PASSWORD_LENGTH))
		else $error("entry length overflow");

	// a result is only loaded when the output side is free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the keypad alarm lock controller. Polling ticks are
// driven on s_axis with random gaps, results are pulled from m_axis with
// random stalls and one long hold-off, and every result beat is compared
// with a cycle-free model of the lock kept inside this file.
// ----------------------------------------------------------------------------
module testbench;
	import kalc_pkg::*;

	localparam int STALL_CYCLES = 300;
	localparam int QUIET_LIMIT  = 2000;

	typedef struct {
		logic        buzzer;
		logic        armed;
		logic        safe;
		mode_t       mode;
		logic [3:0]  length;
		chg_status_t chg;
	} tick_status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // key_code[7:0], distance_cm[15:8]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // buzzer_on[0], armed[1], distance_safe[2],
	                             // mode_code[5:3], entered_length[9:6],
	                             // change_status[11:10], zero[15:12]
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_wdata;

	// lock model state
	logic        m_armed;
	logic        m_trip;
	mode_t       m_mode;
	logic [3:0]  m_entry [PASSWORD_LENGTH];
	logic [3:0]  m_password [PASSWORD_LENGTH];
	int          m_len;
	int          m_count;
	logic [7:0]  m_setpoint;
	logic [7:0]  m_tolerance;

	tick_status_t pending_status [$];

	int failures     = 0;
	int items_sent   = 0;
	int quiet_cycles = 0;
	bit src_idle_on  = 1'b0;
	bit sink_idle_on = 1'b0;
	bit stall_request = 1'b0;

	keypad_alarm_lock_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// lock model
	// ------------------------------------------------------------------------
	task automatic reset_lock_model();
		int i;
		m_armed     = 1'b1;
		m_trip      = 1'b0;
		m_mode      = MODE_INSERT;
		m_len       = 0;
		m_count     = 0;
		m_setpoint  = SETPOINT_RESET;
		m_tolerance = TOLERANCE_RESET;
		for (i = 0; i < PASSWORD_LENGTH; i++) begin
			m_entry[i]    = 4'd0;
			m_password[i] = 4'(i % 10);
		end
	endtask

	task automatic clear_entry();
		m_mode  = MODE_INSERT;
		m_len   = 0;
		m_count = 0;
	endtask

	task automatic predict_tick(input logic [7:0] key, input logic [7:0] distance);
		tick_status_t want;
		mode_t        prev;
		int           diff;
		int           tol;
		logic         is_digit;
		logic         pw_ok;
		int           i;
		prev     = m_mode;
		want.chg = CHG_NONE;
		diff     = int'(m_setpoint) - int'(distance);
		tol      = int'(m_tolerance);
		want.safe = (diff <= tol) && (diff >= -tol);
		if (!want.safe)
			m_trip = 1'b1;
		// buzzer uses the armed flag from before the key
		want.buzzer = m_armed && (!want.safe || m_trip);
		is_digit = (key >= KEY_DIGIT_0) && (key <= KEY_DIGIT_9);
		case (key)
			KEY_INSERT: m_mode = MODE_INSERT;
			KEY_CHANGE: m_mode = MODE_CHANGE;
			KEY_ENTER:  m_mode = MODE_ENTER;
			KEY_DELETE: m_mode = MODE_DELETE;
			KEY_CANCEL: m_mode = MODE_CANCEL;
			KEY_ARM:    m_mode = MODE_ARM;
			default: ;
		endcase
		if (prev == MODE_INSERT && m_mode == MODE_ENTER) begin
			pw_ok = (m_len == PASSWORD_LENGTH);
			for (i = 0; i < PASSWORD_LENGTH; i++)
				if (pw_ok && m_entry[i] != m_password[i])
					pw_ok = 1'b0;
			if (pw_ok) begin
				m_armed = 1'b0;
				m_trip  = 1'b0;
			end else begin
				m_armed = 1'b1;
			end
			clear_entry();
		end else if (prev == MODE_CHANGE && m_mode == MODE_ENTER) begin
			if (m_len == PASSWORD_LENGTH && !m_armed) begin
				for (i = 0; i < PASSWORD_LENGTH; i++)
					m_password[i] = m_entry[i];
				want.chg = CHG_DONE;
			end else begin
				want.chg = CHG_REFUSED;
			end
			clear_entry();
		end else if (m_mode == MODE_INSERT || m_mode == MODE_CHANGE) begin
			if (is_digit) begin
				if (m_count < PASSWORD_LENGTH) begin
					m_entry[m_count] = 4'(key - KEY_DIGIT_0);
					m_len = m_count + 1;
				end
				if (m_count < int'(CNT_MAX))
					m_count++;
			end
		end else if (m_mode == MODE_DELETE) begin
			m_len   = 0;
			m_count = 0;
			m_mode  = prev;
		end else if (m_mode == MODE_CANCEL) begin
			clear_entry();
		end else if (m_mode == MODE_ARM) begin
			m_armed = 1'b1;
			m_trip  = 1'b0;
			clear_entry();
		end
		want.armed  = m_armed;
		want.mode   = m_mode;
		want.length = 4'(m_len);
		pending_status.push_back(want);
	endtask

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_tick(input logic [7:0] key, input logic [7:0] distance);
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {distance, key};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_tick(key, distance);
		items_sent++;
		@(negedge clk);
	endtask

	// mostly inside the window, sometimes anywhere
	function automatic logic [7:0] pick_distance();
		int lo;
		int hi;
		lo = int'(m_setpoint) - int'(m_tolerance);
		hi = int'(m_setpoint) + int'(m_tolerance);
		if (lo < 0)
			lo = 0;
		if (hi > 255)
			hi = 255;
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(hi, lo));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_key(input logic [7:0] key);
		send_tick(key, pick_distance());
	endtask

	task automatic settle_idle();
		s_axis_tvalid = 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_SETPOINT)
			m_setpoint = value;
		else
			m_tolerance = value;
	endtask

	// opener, digits (stored password or random), enter; with stray ticks
	task automatic send_entry_run(input logic [7:0] opener, input bit use_stored,
	                              input int count);
		int         i;
		logic [3:0] d;
		send_key(opener);
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_key(8'h00);
			if ($urandom_range(0, 59) == 0)
				send_key(KEY_DELETE);
			if (use_stored && i < PASSWORD_LENGTH)
				d = m_password[i];
			else
				d = 4'($urandom_range(0, 9));
			send_key(KEY_DIGIT_0 + 8'(d));
		end
		send_key(KEY_ENTER);
	endtask

	task automatic run_random(input int count, input bit vary_idle);
		int start;
		int pick;
		int digits;
		start = items_sent;
		while (items_sent - start < count) begin
			if (vary_idle) begin
				if ($urandom_range(0, 24) == 0)
					src_idle_on = !src_idle_on;
				if ($urandom_range(0, 24) == 0)
					sink_idle_on = !sink_idle_on;
			end
			digits = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : PASSWORD_LENGTH;
			pick   = $urandom_range(0, 99);
			if (pick < 40)
				send_entry_run(KEY_INSERT, $urandom_range(0, 9) < 7, digits);
			else if (pick < 60)
				send_entry_run(KEY_CHANGE, 1'b0, digits);
			else if (pick < 67)
				send_key(KEY_ARM);
			else if (pick < 72)
				send_key(KEY_CANCEL);
			else
				send_key(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		int i;
		send_tick(8'h00, 8'd28);
		send_tick(8'hFF, 8'd0);           // unknown key, far out: trip latches
		send_tick(KEY_ARM, 8'd255);
		send_tick(KEY_DIGIT_0 + 8'd3, 8'd28); // arm leaves insert mode, digit counts
		send_tick(KEY_ENTER, 8'd31);      // one-digit entry, upper window edge
		send_tick(KEY_INSERT, 8'd25);     // lower window edge
		send_tick(KEY_DIGIT_9, 8'd32);    // just outside
		send_tick(KEY_ENTER, 8'd28);      // short entry is a miss
		send_tick(KEY_INSERT, 8'd28);
		for (i = 0; i < PASSWORD_LENGTH; i++)
			send_tick(KEY_DIGIT_0 + 8'(m_password[i]), 8'd28);
		send_tick(KEY_DIGIT_9, 8'd28);    // ninth digit dropped
		send_tick(KEY_ENTER, 8'd28);      // match disarms
		send_tick(KEY_CHANGE, 8'd28);
		send_tick(KEY_DIGIT_0 + 8'd4, 8'd28);
		send_tick(KEY_DELETE, 8'd28);     // back to change mode, buffer empty
		send_tick(KEY_CANCEL, 8'd28);
		send_tick(KEY_CHANGE, 8'd28);
		send_tick(KEY_ENTER, 8'd28);      // short change refused
	endtask

	// digit count runs past 255 and must saturate
	task automatic test_digit_saturation();
		int i;
		send_key(KEY_INSERT);
		for (i = 0; i < 260; i++) begin
			if (i < PASSWORD_LENGTH)
				send_key(KEY_DIGIT_0 + 8'(m_password[i]));
			else
				send_key(KEY_DIGIT_0 + 8'($urandom_range(0, 9)));
		end
		send_key(KEY_ENTER);
	endtask

	task automatic test_backpressure();
		src_idle_on   = 1'b0;
		stall_request = 1'b1;
		run_random(60, 1'b0);
	endtask

	task automatic test_config_sweep();
		logic [7:0] setpoints [6];
		logic [7:0] tolerances [6];
		int         p;
		setpoints  = '{8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom_range(0, 255)), 8'd128};
		tolerances = '{8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom_range(0, 40)), 8'd1};
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		run_random(180, 1'b1);
		for (p = 0; p < 6; p++) begin
			settle_idle();
			write_reg(REG_SETPOINT, setpoints[p]);
			write_reg(REG_TOLERANCE, tolerances[p]);
			run_random(180, 1'b1);
		end
		settle_idle();
		write_reg(REG_TOLERANCE, TOLERANCE_RESET);
		write_reg(REG_SETPOINT, SETPOINT_RESET);
	endtask

	task automatic test_closing_run();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		run_random(150, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				m_axis_tready = 1'b0;
				repeat (STALL_CYCLES - 1) @(negedge clk);
				stall_request = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		tick_status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_status.size() == 0) begin
				$error("result beat with nothing expected, tdata %h", m_axis_tdata);
				failures++;
			end else begin
				want = pending_status.pop_front();
				compare_field("buzzer_on", want.buzzer, m_axis_tdata[0]);
				compare_field("armed", want.armed, m_axis_tdata[1]);
				compare_field("distance_safe", want.safe, m_axis_tdata[2]);
				compare_field("mode_code", int'(want.mode), m_axis_tdata[5:3]);
				compare_field("entered_length", want.length, m_axis_tdata[9:6]);
				compare_field("change_status", int'(want.chg), m_axis_tdata[11:10]);
			end
		end
	end

	// watchdog: cycles without any beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 16'h0000;
		cfg_we        = 1'b0;
		cfg_index     = REG_SETPOINT;
		cfg_wdata     = 8'h00;
		reset_lock_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_digit_saturation();
		test_backpressure();
		test_config_sweep();
		test_closing_run();

		settle_idle();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
